>>> design/mdesc_pkg.sv
`default_nettype none

package mdesc_pkg;

    // Character codes
    localparam logic [7:0] CH_LT     = 8'h3C;  // <
    localparam logic [7:0] CH_GT     = 8'h3E;  // >
    localparam logic [7:0] CH_EQ     = 8'h3D;  // =
    localparam logic [7:0] CH_MINUS  = 8'h2D;  // -
    localparam logic [7:0] CH_EXCL   = 8'h21;  // !
    localparam logic [7:0] CH_COL    = 8'h3A;  // :
    localparam logic [7:0] CH_BSLASH = 8'h5C;  // backslash
    localparam logic [7:0] CH_TICK   = 8'h60;  // `
    localparam logic [7:0] CH_STAR   = 8'h2A;  // *
    localparam logic [7:0] CH_LBRACE = 8'h7B;  // {
    localparam logic [7:0] CH_RBRACE = 8'h7D;  // }
    localparam logic [7:0] CH_LBRACK = 8'h5B;  // [
    localparam logic [7:0] CH_RBRACK = 8'h5D;  // ]

    // Input request and output result
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       run_last;
        logic       text_last;
    } out_item_t;

    // Held-character state of the lookahead
    typedef enum logic [6:0] {
        HOLD_NONE  = 7'b0000001,
        HOLD_LT    = 7'b0000010,
        HOLD_GT    = 7'b0000100,
        HOLD_EQ    = 7'b0001000,
        HOLD_MINUS = 7'b0010000,
        HOLD_EXCL  = 7'b0100000,
        HOLD_COL   = 7'b1000000
    } hold_t;

    // Entity codes
    typedef enum logic [3:0] {
        ENT_LE  = 4'd0,
        ENT_LA  = 4'd1,
        ENT_LL  = 4'd2,
        ENT_GE  = 4'd3,
        ENT_GG  = 4'd4,
        ENT_RA2 = 4'd5,
        ENT_EQ  = 4'd6,
        ENT_RA  = 4'd7,
        ENT_NE  = 4'd8,
        ENT_CC  = 4'd9,
        ENT_CE  = 4'd10
    } ent_t;

    // Classified work for one request, passed from front to back.
    // Output order: entity, or held(pre) [\] ch, then held(post).
    typedef struct packed {
        logic       ent_hit;
        ent_t       ent;
        hold_t      pre;
        logic       esc;
        logic       ch_v;
        logic [7:0] ch;
        hold_t      post;
        logic       eot;
    } job_t;

    // Up to eight bytes, first byte in the top byte lane
    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  len;
    } seq_t;

    function automatic seq_t ent_text(ent_t e);
        seq_t s;
        s.data = '0;
        s.len  = 4'd7;
        unique case (e)
            ENT_LE:  s.data = {"&#8804;", 8'h00};
            ENT_LA:  begin s.data = "&#10229;"; s.len = 4'd8; end
            ENT_LL:  s.data = {"&#8810;", 8'h00};
            ENT_GE:  s.data = {"&#8805;", 8'h00};
            ENT_GG:  s.data = {"&#8811;", 8'h00};
            ENT_RA2: begin s.data = "&#10233;"; s.len = 4'd8; end
            ENT_EQ:  s.data = {"&#8801;", 8'h00};
            ENT_RA:  begin s.data = "&#10230;"; s.len = 4'd8; end
            ENT_NE:  s.data = {"&#8800;", 8'h00};
            ENT_CC:  s.data = {"&#8759;", 8'h00};
            ENT_CE:  s.data = {"&#8788;", 8'h00};
            default: s.len = 4'd0;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> design/markdown_escape_digraph_transducer_top.sv
`default_nettype none
// With queue and output register idle, a request's job is written into the job queue and
// then loaded into the output register, which drives the result ports.
// Throughput: one result byte per cycle while pop keeps up, set by the single output register;
// a request produces 0 to 8 bytes; one-byte requests go back to back.
// The job queue (QUEUE_DEPTH entries) lets input continue while an entity expansion drains.
// Reset: asynchronous, active low; clears held byte, queue and output valid; no clearing pass.
module markdown_escape_digraph_transducer_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire mdesc_pkg::in_item_t  item,
    output logic                      empty,
    input  wire logic                 pop,
    output mdesc_pkg::out_item_t      result
);

    import mdesc_pkg::*;

    logic  accept;
    job_t  f_job;
    logic  f_job_valid;
    logic  [$bits(job_t)-1:0] q_rd_data;
    logic  q_empty;
    logic  q_full;
    logic  q_pop;
    logic  result_valid;

    assign accept = push && !full;
    assign full   = q_full;
    assign empty  = !result_valid;

    // Front: hold lookahead state and classify each request
    mdesc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .job       (f_job),
        .job_valid (f_job_valid)
    );

    // Job queue between front and back
    mdesc_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (f_job_valid),
        .wr_data (f_job),
        .rd_en   (q_pop),
        .rd_data (q_rd_data),
        .empty   (q_empty),
        .full    (q_full)
    );

    // Back: expand jobs into result bytes
    mdesc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job          (job_t'(q_rd_data)),
        .job_valid    (!q_empty),
        .job_take     (q_pop),
        .result       (result),
        .result_valid (result_valid),
        .result_take  (pop)
    );

    // Back never takes a job from an empty queue
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job taken from empty queue");

    // Front never writes into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        f_job_valid |-> !q_full)
        else $error("job written into full queue");

    // A job into an idle back end passes through the queue and is loaded into the output register
    a_idle_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (f_job_valid && q_empty && empty) |-> ##2 !empty)
        else $error("result missing after idle request");

endmodule

`default_nettype wire

>>> design/mdesc_fifo.sv
`default_nettype none

module mdesc_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             wr_en,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    output logic      [WIDTH-1:0] rd_data,
    output logic                  empty,
    output logic                  full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_FULL);
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> design/mdesc_front.sv
`default_nettype none

module mdesc_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               accept,
    input  wire mdesc_pkg::in_item_t item,
    output mdesc_pkg::job_t         job,
    output logic                    job_valid
);

    import mdesc_pkg::*;

    typedef struct packed {
        logic hit;
        ent_t ent;
    } match_t;

    hold_t pending_mode_reg, pending_mode_next;
    hold_t hold_after;
    match_t pair;

    // Known pair of held character and current byte
    function automatic match_t pair_match(hold_t h, logic [7:0] c);
        match_t m;
        m.hit = 1'b0;
        m.ent = ENT_LE;
        unique case (h)
            HOLD_LT:
            begin
                if (c == CH_EQ)         begin m.hit = 1'b1; m.ent = ENT_LE; end
                else if (c == CH_MINUS) begin m.hit = 1'b1; m.ent = ENT_LA; end
                else if (c == CH_LT)    begin m.hit = 1'b1; m.ent = ENT_LL; end
            end
            HOLD_GT:
            begin
                if (c == CH_EQ)      begin m.hit = 1'b1; m.ent = ENT_GE; end
                else if (c == CH_GT) begin m.hit = 1'b1; m.ent = ENT_GG; end
            end
            HOLD_EQ:
            begin
                if (c == CH_GT)      begin m.hit = 1'b1; m.ent = ENT_RA2; end
                else if (c == CH_EQ) begin m.hit = 1'b1; m.ent = ENT_EQ; end
            end
            HOLD_MINUS:
            begin
                if (c == CH_GT) begin m.hit = 1'b1; m.ent = ENT_RA; end
            end
            HOLD_EXCL:
            begin
                if (c == CH_EQ) begin m.hit = 1'b1; m.ent = ENT_NE; end
            end
            HOLD_COL:
            begin
                if (c == CH_COL)     begin m.hit = 1'b1; m.ent = ENT_CC; end
                else if (c == CH_EQ) begin m.hit = 1'b1; m.ent = ENT_CE; end
            end
            default: m.hit = 1'b0;
        endcase
        return m;
    endfunction

    // Bytes that open a lookahead
    function automatic hold_t start_hold(logic [7:0] c);
        hold_t h;
        unique case (c)
            CH_LT:    h = HOLD_LT;
            CH_GT:    h = HOLD_GT;
            CH_EQ:    h = HOLD_EQ;
            CH_MINUS: h = HOLD_MINUS;
            CH_EXCL:  h = HOLD_EXCL;
            CH_COL:   h = HOLD_COL;
            default:  h = HOLD_NONE;
        endcase
        return h;
    endfunction

    // Bytes that take a backslash prefix
    function automatic logic needs_esc(logic [7:0] c);
        return (c == CH_BSLASH) || (c == CH_TICK) || (c == CH_STAR) ||
               (c == CH_LBRACE) || (c == CH_RBRACE) ||
               (c == CH_LBRACK) || (c == CH_RBRACK);
    endfunction

    // Classify the request against the held character
    always_comb
    begin
        pair        = pair_match(pending_mode_reg, item.char_in);
        job.ent_hit = 1'b0;
        job.ent     = pair.ent;
        job.pre     = HOLD_NONE;
        job.esc     = 1'b0;
        job.ch_v    = 1'b0;
        job.ch      = item.char_in;
        job.post    = HOLD_NONE;
        job.eot     = item.end_of_text;
        hold_after  = HOLD_NONE;

        if (pending_mode_reg != HOLD_NONE)
        begin
            if (pair.hit)
            begin
                job.ent_hit = 1'b1;
            end
            else
            begin
                job.pre  = pending_mode_reg;
                job.ch_v = 1'b1;
            end
        end
        else
        begin
            hold_after = start_hold(item.char_in);
            if (hold_after == HOLD_NONE)
            begin
                job.ch_v = 1'b1;
                job.esc  = needs_esc(item.char_in);
            end
        end

        // end of text flushes a newly held character
        if (item.end_of_text)
        begin
            job.post   = hold_after;
            hold_after = HOLD_NONE;
        end

        pending_mode_next = accept ? hold_after : pending_mode_reg;
        job_valid = accept && (job.ent_hit || job.ch_v || job.eot);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_mode_reg <= HOLD_NONE;
        end
        else
        begin
            pending_mode_reg <= pending_mode_next;
        end
    end

endmodule

`default_nettype wire

>>> design/mdesc_back.sv
`default_nettype none

module mdesc_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire mdesc_pkg::job_t     job,
    input  wire logic                job_valid,
    output logic                     job_take,
    output mdesc_pkg::out_item_t     result,
    output logic                     result_valid,
    input  wire logic                result_take
);

    import mdesc_pkg::*;

    typedef struct packed {
        logic [1:0] len;
        logic [7:0] b0;
        logic [7:0] b1;
    } held_t;

    seq_t        exp_seq;
    logic [63:0] shifted;
    logic [7:0]  cur_byte;
    logic        cur_last;
    logic        advance;

    logic [2:0]  idx_reg, idx_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_reg, out_next;

    // Held character written when no pair matched
    function automatic held_t held_text(hold_t h);
        held_t t;
        t.len = 2'd1;
        t.b0  = 8'h00;
        t.b1  = 8'h00;
        unique case (h)
            HOLD_LT:    t.b0 = CH_LT;
            HOLD_GT:    begin t.len = 2'd2; t.b0 = CH_BSLASH; t.b1 = CH_GT; end
            HOLD_EQ:    t.b0 = CH_EQ;
            HOLD_MINUS: t.b0 = CH_MINUS;
            HOLD_EXCL:  begin t.len = 2'd2; t.b0 = CH_BSLASH; t.b1 = CH_EXCL; end
            HOLD_COL:   t.b0 = CH_COL;
            default:    t.len = 2'd0;
        endcase
        return t;
    endfunction

    // Expand a job into its byte sequence
    function automatic seq_t expand(job_t j);
        seq_t  s;
        held_t hp;
        held_t hq;
        s  = ent_text(j.ent);
        hp = held_text(j.pre);
        hq = held_text(j.post);
        if (!j.ent_hit)
        begin
            s.data = '0;
            s.len  = 4'd0;
            if (hp.len != 2'd0)
            begin
                s.data = s.data | ({hp.b0, 56'h0} >> {s.len, 3'b000});
                s.len  = s.len + 4'd1;
            end
            if (hp.len == 2'd2)
            begin
                s.data = s.data | ({hp.b1, 56'h0} >> {s.len, 3'b000});
                s.len  = s.len + 4'd1;
            end
            if (j.esc)
            begin
                s.data = s.data | ({CH_BSLASH, 56'h0} >> {s.len, 3'b000});
                s.len  = s.len + 4'd1;
            end
            if (j.ch_v)
            begin
                s.data = s.data | ({j.ch, 56'h0} >> {s.len, 3'b000});
                s.len  = s.len + 4'd1;
            end
            if (hq.len != 2'd0)
            begin
                s.data = s.data | ({hq.b0, 56'h0} >> {s.len, 3'b000});
                s.len  = s.len + 4'd1;
            end
            if (hq.len == 2'd2)
            begin
                s.data = s.data | ({hq.b1, 56'h0} >> {s.len, 3'b000});
                s.len  = s.len + 4'd1;
            end
        end
        return s;
    endfunction

    // Current byte of the head job
    always_comb
    begin
        exp_seq  = expand(job);
        shifted  = exp_seq.data << {idx_reg, 3'b000};
        cur_byte = shifted[63:56];
        cur_last = ({1'b0, idx_reg} == (exp_seq.len - 4'd1));
    end

    // Output register loads when empty or being drained
    assign advance  = job_valid && (!out_valid_reg || result_take);
    assign job_take = advance && cur_last;

    always_comb
    begin
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance)
        begin
            out_valid_next     = 1'b1;
            out_next.char_out  = cur_byte;
            out_next.run_last  = cur_last;
            out_next.text_last = cur_last && job.eot;
            idx_next           = cur_last ? 3'd0 : idx_reg + 3'd1;
        end
        else if (result_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result       = out_reg;
    assign result_valid = out_valid_reg;

endmodule

`default_nettype wire
